@@ rtl/fste_pkg.sv @@
// ----------------------------------------------------------------------------
// fste_pkg: shared types and constants of the flat-shaded triangle emitter
// Field widths, the face record passed from the normal unit to the emitter,
// and the sizing of the queue between them.
// ----------------------------------------------------------------------------
package fste_pkg;

  // width of every vertex, normal and coordinate port
  localparam int FIELD_W = 32;

  // digit width of the shared sequential multiplier
  localparam int DIGIT_W = 16;

  // entries in the queue between the normal unit and the emitter
  localparam int FACE_DEPTH = 2;

  // one finished face: three vertices, the shared unit normal, degenerate flag
  typedef struct packed {
    logic [2:0][2:0][FIELD_W-1:0] vert;
    logic [2:0][FIELD_W-1:0]      nrm;
    logic                         degen;
  } face_t;

endpackage

@@ rtl/fste_normal.sv @@
// ----------------------------------------------------------------------------
// fste_normal: face normal unit
// Takes one triangle, forms the cross product of its edges with a shared
// digit-serial multiplier, then scales each component to unit length by a
// restoring division followed by a digit-by-digit square root.
// ----------------------------------------------------------------------------
module fste_normal #(
  parameter int CW  = 32,
  parameter int NFB = 30
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            start,
  input  logic [2:0][2:0][fste_pkg::FIELD_W-1:0]          vin,
  output logic                                            idle,
  output logic                                            face_valid,
  input  logic                                            face_full,
  output fste_pkg::face_t                                 face
);

  localparam int FW    = fste_pkg::FIELD_W;
  localparam int DIG   = fste_pkg::DIGIT_W;
  localparam int DW    = CW + 1;
  localparam int PW    = 2 * CW + 2;
  localparam int STEPS = (PW + DIG - 1) / DIG;
  localparam int MW    = STEPS * DIG;
  localparam int SQW   = 2 * PW;
  localparam int SW    = SQW + 2;
  localparam int QW    = 2 * NFB + 1;
  localparam int RW    = NFB + 4;
  localparam int CNTW  = $clog2(QW + STEPS + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_XLOAD, ST_XA, ST_XB, ST_SQLOAD, ST_SQ, ST_CHECK,
    ST_DIVLOAD, ST_DIV, ST_SQRTLOAD, ST_SQRT, ST_PUSH
  } state_t;

  state_t state;

  logic signed [DW-1:0]    u [3];
  logic signed [DW-1:0]    w [3];
  logic signed [PW:0]      c [3];
  logic [SQW-1:0]          sq [3];
  logic [FW-1:0]           nrm [3];
  logic [2:0][2:0][FW-1:0] vert;
  logic                    degen;

  logic [1:0]              k;
  logic [CNTW-1:0]         cnt;

  logic [MW-1:0]           mul_a;
  logic [2*MW-1:0]         mul_p;
  logic                    mul_sign;
  logic [MW+DIG-1:0]       mul_pp;
  logic [MW+DIG-1:0]       mul_sum;
  logic [2*MW-1:0]         mul_p_next;

  logic signed [PW:0]      acc;
  logic signed [PW:0]      pmag;
  logic signed [PW:0]      prod_s;
  logic signed [PW:0]      cneg;
  logic [PW-1:0]           cmag;
  logic [SW-1:0]           sum;

  logic [SW:0]             rem;
  logic [SW:0]             cand;
  logic                    ge;
  logic [QW-1:0]           quot;

  logic [2*NFB+1:0]        sd;
  logic [NFB:0]            root;
  logic [NFB:0]            root_next;
  logic [RW-1:0]           srem;
  logic [RW-1:0]           srem_next;
  logic [RW-1:0]           stemp;
  logic [RW-1:0]           trial;
  logic [FW-1:0]           qval;

  // magnitude of an edge difference, widened for the multiplier
  function automatic logic [MW-1:0] absx(input logic signed [DW-1:0] v);
    logic [DW-1:0] m;
    m = v[DW-1] ? DW'(-v) : DW'(v);
    return MW'(m);
  endfunction

  // one multiplier digit: add partial product, shift one digit out
  assign mul_pp     = mul_a * mul_p[DIG-1:0];
  assign mul_sum    = {{DIG{1'b0}}, mul_p[2*MW-1:MW]} + mul_pp;
  assign mul_p_next = {mul_sum, mul_p[MW-1:DIG]};

  // signed product and magnitude of the oldest cross component
  assign pmag   = {1'b0, mul_p[PW-1:0]};
  assign prod_s = mul_sign ? -pmag : pmag;
  assign cneg   = -c[0];
  assign cmag   = c[0][PW] ? cneg[PW-1:0] : c[0][PW-1:0];

  // one restoring division step
  assign cand = (cnt == '0) ? rem : {rem[SW-1:0], 1'b0};
  assign ge   = cand >= {1'b0, sum};

  // one square root digit
  assign stemp = {srem[RW-3:0], sd[2*NFB+1:2*NFB]};
  assign trial = RW'({root, 2'b01});
  always_comb begin
    if (stemp >= trial) begin
      srem_next = stemp - trial;
      root_next = {root[NFB-1:0], 1'b1};
    end else begin
      srem_next = stemp;
      root_next = {root[NFB-1:0], 1'b0};
    end
  end
  assign qval = c[0][PW] ? -FW'(root_next) : FW'(root_next);

  assign idle       = (state == ST_IDLE);
  assign face_valid = (state == ST_PUSH);
  assign face.vert  = vert;
  assign face.nrm   = {nrm[2], nrm[1], nrm[0]};
  assign face.degen = degen;

  // sequencer: cross product, squares, then unit scaling per component
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      k     <= '0;
      cnt   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            for (int a = 0; a < 3; a++) begin
              u[a] <= DW'(signed'(vin[2][a][CW-1:0])) - DW'(signed'(vin[0][a][CW-1:0]));
              w[a] <= DW'(signed'(vin[1][a][CW-1:0])) - DW'(signed'(vin[0][a][CW-1:0]));
              for (int v = 0; v < 3; v++) begin
                vert[v][a] <= FW'(signed'(vin[v][a][CW-1:0]));
              end
            end
            sum   <= '0;
            k     <= '0;
            state <= ST_XLOAD;
          end
        end
        ST_XLOAD: begin
          mul_a    <= absx(u[1]);
          mul_p    <= {{MW{1'b0}}, absx(w[2])};
          mul_sign <= u[1][DW-1] ^ w[2][DW-1];
          cnt      <= '0;
          state    <= ST_XA;
        end
        ST_XA: begin
          if (cnt != CNTW'(STEPS)) begin
            mul_p <= mul_p_next;
            cnt   <= cnt + 1'b1;
          end else begin
            acc      <= prod_s;
            mul_a    <= absx(u[2]);
            mul_p    <= {{MW{1'b0}}, absx(w[1])};
            mul_sign <= u[2][DW-1] ^ w[1][DW-1];
            cnt      <= '0;
            state    <= ST_XB;
          end
        end
        ST_XB: begin
          if (cnt != CNTW'(STEPS)) begin
            mul_p <= mul_p_next;
            cnt   <= cnt + 1'b1;
          end else begin
            // shift the finished component in, rotate the edges
            c[0] <= c[1];
            c[1] <= c[2];
            c[2] <= acc - prod_s;
            u[0] <= u[1]; u[1] <= u[2]; u[2] <= u[0];
            w[0] <= w[1]; w[1] <= w[2]; w[2] <= w[0];
            if (k == 2'd2) begin
              k     <= '0;
              state <= ST_SQLOAD;
            end else begin
              k     <= k + 1'b1;
              state <= ST_XLOAD;
            end
          end
        end
        ST_SQLOAD: begin
          mul_a <= MW'(cmag);
          mul_p <= {{MW{1'b0}}, MW'(cmag)};
          cnt   <= '0;
          state <= ST_SQ;
        end
        ST_SQ: begin
          if (cnt != CNTW'(STEPS)) begin
            mul_p <= mul_p_next;
            cnt   <= cnt + 1'b1;
          end else begin
            sq[0] <= sq[1];
            sq[1] <= sq[2];
            sq[2] <= mul_p[SQW-1:0];
            sum   <= sum + SW'(mul_p[SQW-1:0]);
            c[0]  <= c[1]; c[1] <= c[2]; c[2] <= c[0];
            if (k == 2'd2) begin
              k     <= '0;
              state <= ST_CHECK;
            end else begin
              k     <= k + 1'b1;
              state <= ST_SQLOAD;
            end
          end
        end
        ST_CHECK: begin
          if (sum == '0) begin
            degen <= 1'b1;
            for (int a = 0; a < 3; a++) begin
              nrm[a] <= '0;
            end
            state <= ST_PUSH;
          end else begin
            degen <= 1'b0;
            state <= ST_DIVLOAD;
          end
        end
        ST_DIVLOAD: begin
          rem   <= (SW + 1)'(sq[0]);
          quot  <= '0;
          cnt   <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          rem  <= ge ? cand - {1'b0, sum} : cand;
          quot <= {quot[QW-2:0], ge};
          cnt  <= cnt + 1'b1;
          if (cnt == CNTW'(QW - 1)) begin
            state <= ST_SQRTLOAD;
          end
        end
        ST_SQRTLOAD: begin
          sd    <= {1'b0, quot};
          root  <= '0;
          srem  <= '0;
          cnt   <= '0;
          state <= ST_SQRT;
        end
        ST_SQRT: begin
          sd   <= {sd[2*NFB-1:0], 2'b00};
          root <= root_next;
          srem <= srem_next;
          cnt  <= cnt + 1'b1;
          if (cnt == CNTW'(NFB)) begin
            nrm[0] <= nrm[1];
            nrm[1] <= nrm[2];
            nrm[2] <= qval;
            c[0]   <= c[1]; c[1] <= c[2]; c[2] <= c[0];
            sq[0]  <= sq[1]; sq[1] <= sq[2]; sq[2] <= sq[0];
            if (k == 2'd2) begin
              k     <= '0;
              state <= ST_PUSH;
            end else begin
              k     <= k + 1'b1;
              state <= ST_DIVLOAD;
            end
          end
        end
        ST_PUSH: begin
          if (!face_full) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/fste_fifo.sv @@
// ----------------------------------------------------------------------------
// fste_fifo: face queue
// Short queue of finished faces between the normal unit and the emitter.
// ----------------------------------------------------------------------------
module fste_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  fste_pkg::face_t wdata,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output fste_pkg::face_t rdata
);

  localparam int DEPTH = fste_pkg::FACE_DEPTH;
  localparam int PTRW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW  = $clog2(DEPTH + 1);

  fste_pkg::face_t mem [DEPTH];
  logic [PTRW-1:0] wptr;
  logic [PTRW-1:0] rptr;
  logic [CNTW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == CNTW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  // write entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PTRW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PTRW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CNTW'(do_push) - CNTW'(do_pop);
    end
  end

endmodule

@@ rtl/fste_emit.sv @@
// ----------------------------------------------------------------------------
// fste_emit: vertex emitter
// Unrolls each queued face into three vertex beats with a running index,
// through one output register that loads whenever it is free or drained.
// ----------------------------------------------------------------------------
module fste_emit #(
  parameter int IW = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  fste_pkg::face_t               face,
  input  logic                          face_empty,
  output logic                          face_pop,
  output logic [fste_pkg::FIELD_W-1:0]  vertex_x,
  output logic [fste_pkg::FIELD_W-1:0]  vertex_y,
  output logic [fste_pkg::FIELD_W-1:0]  vertex_z,
  output logic [fste_pkg::FIELD_W-1:0]  normal_x,
  output logic [fste_pkg::FIELD_W-1:0]  normal_y,
  output logic [fste_pkg::FIELD_W-1:0]  normal_z,
  output logic [IW-1:0]                 vertex_index,
  output logic                          last_of_face,
  output logic                          degenerate,
  output logic                          empty,
  input  logic                          pop
);

  logic          ovalid;
  logic [1:0]    vk;
  logic [IW-1:0] next_index;
  logic          load;

  assign empty    = !ovalid;
  assign load     = !face_empty && (!ovalid || pop);
  assign face_pop = load && (vk == 2'd2);

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      vertex_x     <= face.vert[vk][0];
      vertex_y     <= face.vert[vk][1];
      vertex_z     <= face.vert[vk][2];
      normal_x     <= face.nrm[0];
      normal_y     <= face.nrm[1];
      normal_z     <= face.nrm[2];
      vertex_index <= next_index;
      last_of_face <= (vk == 2'd2);
      degenerate   <= face.degen;
    end
  end

  // hold beat valid, advance vertex and index counters
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid     <= 1'b0;
      vk         <= '0;
      next_index <= '0;
    end else begin
      if (load) begin
        ovalid     <= 1'b1;
        vk         <= (vk == 2'd2) ? 2'd0 : vk + 1'b1;
        next_index <= next_index + 1'b1;
      end else if (pop) begin
        ovalid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/flat_shaded_triangle_emitter.sv @@
// ----------------------------------------------------------------------------
// flat_shaded_triangle_emitter: triangle to flat-shaded vertex stream
// Computes the unit face normal of a triangle and emits its three vertices.
// ----------------------------------------------------------------------------
// Input channel: a triangle (nine signed coordinates) is taken at a rising
// edge with push high and full low. Result channel: while empty is low the
// oldest vertex beat sits on the result ports; it is taken when pop is high.
// Each triangle gives three beats in vertex order, the third with
// last_of_face set, all carrying the same Q2.30 normal.
// The normal unit works on one triangle at a time and keeps full high until
// it has passed its face to the queue (a degenerate triangle skips scaling):
// a 16-bit-digit multiplier forms the cross product and squares, then per
// component a one-bit-a-cycle divider and a two-bit-a-cycle square root set
// the length. The first beat of a face is registered in the face queue and
// then in the output register. A two-deep face queue and the output register
// let the normal unit start the next triangle while the receiver stalls; once
// both are full the normal unit holds its face and full stays high. The
// emitter sends one beat per cycle while pop is high and a face is queued.
// Reset empties the queue, drops any triangle in flight and clears the
// running vertex index to zero.
// ----------------------------------------------------------------------------
module flat_shaded_triangle_emitter #(
  parameter int COORD_WIDTH      = 32,
  parameter int NORMAL_FRAC_BITS = 30,
  parameter int INDEX_WIDTH      = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [fste_pkg::FIELD_W-1:0]  first_x,
  input  logic [fste_pkg::FIELD_W-1:0]  first_y,
  input  logic [fste_pkg::FIELD_W-1:0]  first_z,
  input  logic [fste_pkg::FIELD_W-1:0]  second_x,
  input  logic [fste_pkg::FIELD_W-1:0]  second_y,
  input  logic [fste_pkg::FIELD_W-1:0]  second_z,
  input  logic [fste_pkg::FIELD_W-1:0]  third_x,
  input  logic [fste_pkg::FIELD_W-1:0]  third_y,
  input  logic [fste_pkg::FIELD_W-1:0]  third_z,
  output logic                          empty,
  input  logic                          pop,
  output logic [fste_pkg::FIELD_W-1:0]  vertex_x,
  output logic [fste_pkg::FIELD_W-1:0]  vertex_y,
  output logic [fste_pkg::FIELD_W-1:0]  vertex_z,
  output logic [fste_pkg::FIELD_W-1:0]  normal_x,
  output logic [fste_pkg::FIELD_W-1:0]  normal_y,
  output logic [fste_pkg::FIELD_W-1:0]  normal_z,
  output logic [INDEX_WIDTH-1:0]        vertex_index,
  output logic                          last_of_face,
  output logic                          degenerate
);

  logic [2:0][2:0][fste_pkg::FIELD_W-1:0] vin;
  logic                                   front_idle;
  logic                                   face_valid;
  logic                                   q_full;
  logic                                   q_empty;
  logic                                   q_pop;
  fste_pkg::face_t                        face_in;
  fste_pkg::face_t                        face_out;

  // gather the triangle
  assign vin[0] = {first_z, first_y, first_x};
  assign vin[1] = {second_z, second_y, second_x};
  assign vin[2] = {third_z, third_y, third_x};
  assign full   = !front_idle;

  fste_normal #(
    .CW  (COORD_WIDTH),
    .NFB (NORMAL_FRAC_BITS)
  ) u_normal (
    .clk        (clk),
    .rst        (rst),
    .start      (push && front_idle),
    .vin        (vin),
    .idle       (front_idle),
    .face_valid (face_valid),
    .face_full  (q_full),
    .face       (face_in)
  );

  fste_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (face_valid),
    .wdata (face_in),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (face_out)
  );

  fste_emit #(
    .IW (INDEX_WIDTH)
  ) u_emit (
    .clk          (clk),
    .rst          (rst),
    .face         (face_out),
    .face_empty   (q_empty),
    .face_pop     (q_pop),
    .vertex_x     (vertex_x),
    .vertex_y     (vertex_y),
    .vertex_z     (vertex_z),
    .normal_x     (normal_x),
    .normal_y     (normal_y),
    .normal_z     (normal_z),
    .vertex_index (vertex_index),
    .last_of_face (last_of_face),
    .degenerate   (degenerate),
    .empty        (empty),
    .pop          (pop)
  );

endmodule

@@ tb/sv/tb_flat_shaded_triangle_emitter.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_flat_shaded_triangle_emitter: self-checking bench for the triangle emitter
// Drives directed and random triangles through the push side, predicts the
// exact unit face normal and vertex stream with wide integer arithmetic, and
// compares every popped vertex beat field by field, under random idling on
// both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_flat_shaded_triangle_emitter;

  localparam int NORM_FRAC = 30;
  localparam int RANDOM_FACES = 265;
  localparam int QUIET_TAIL = 40;
  localparam int HOLD_CYCLES = 2000;
  localparam int HOLD_AT_BEAT = 30;

  typedef logic [8:0][fste_pkg::FIELD_W-1:0] tri_t;
  typedef logic signed [79:0] wide_t;
  typedef logic [255:0] big_t;

  typedef struct {
    logic [fste_pkg::FIELD_W-1:0] vx, vy, vz, nx, ny, nz, idx;
    logic                         last, degen;
  } beat_t;

  logic clk, rst, push, full, empty, pop;
  logic [fste_pkg::FIELD_W-1:0] first_x, first_y, first_z;
  logic [fste_pkg::FIELD_W-1:0] second_x, second_y, second_z;
  logic [fste_pkg::FIELD_W-1:0] third_x, third_y, third_z;
  logic [fste_pkg::FIELD_W-1:0] vertex_x, vertex_y, vertex_z;
  logic [fste_pkg::FIELD_W-1:0] normal_x, normal_y, normal_z;
  logic [31:0] vertex_index;
  logic last_of_face, degenerate;

  flat_shaded_triangle_emitter dut (.*);

  tri_t   pending_faces[$];
  beat_t  expected_beats[$];
  logic [31:0] next_vertex_index;
  int     total_faces, faces_sent, beats_seen, degen_faces, errors;
  int     send_gap, recv_stall, hold_left;
  bit     hold_done;

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // s1*s2 - s3*s4 at full width
  function automatic wide_t cross_term(longint s1, longint s2, longint s3, longint s4);
    wide_t a, b, c, d;
    a = s1; b = s2; c = s3; d = s4;
    return a * b - c * d;
  endfunction

  function automatic big_t magnitude(wide_t c);
    wide_t m;
    m = (c < 0) ? -c : c;
    return big_t'(unsigned'(m));
  endfunction

  // largest q with q^2 * |n|^2 <= n_i^2 * 2^60, signed like n_i
  function automatic logic [31:0] unit_part(wide_t c, big_t sumsq);
    big_t target, trial, m;
    logic [31:0] q;
    m = magnitude(c);
    target = (m * m) << (2 * NORM_FRAC);
    q = '0;
    for (int b = NORM_FRAC; b >= 0; b--) begin
      trial = big_t'(q | (32'd1 << b));
      if (trial * trial * sumsq <= target) q = q | (32'd1 << b);
    end
    return (c < 0) ? -q : q;
  endfunction

  // append one triangle to the stimulus queue
  function automatic void queue_face(tri_t t);
    pending_faces = {pending_faces, t};
  endfunction

  // predict the three vertex beats of one accepted triangle
  function automatic void predict_face(tri_t t);
    longint v[9];
    longint ux, uy, uz, wx, wy, wz;
    wide_t cx, cy, cz;
    big_t sumsq;
    logic [31:0] nx, ny, nz;
    logic degen;
    beat_t e;
    for (int i = 0; i < 9; i++) v[i] = longint'(signed'(t[i]));
    ux = v[6] - v[0]; uy = v[7] - v[1]; uz = v[8] - v[2];
    wx = v[3] - v[0]; wy = v[4] - v[1]; wz = v[5] - v[2];
    cx = cross_term(uy, wz, uz, wy);
    cy = cross_term(uz, wx, ux, wz);
    cz = cross_term(ux, wy, uy, wx);
    sumsq = magnitude(cx) * magnitude(cx) + magnitude(cy) * magnitude(cy)
          + magnitude(cz) * magnitude(cz);
    degen = (sumsq == '0);
    nx = '0; ny = '0; nz = '0;
    if (!degen) begin
      nx = unit_part(cx, sumsq);
      ny = unit_part(cy, sumsq);
      nz = unit_part(cz, sumsq);
    end else begin
      degen_faces++;
    end
    for (int k = 0; k < 3; k++) begin
      e.vx = t[3*k]; e.vy = t[3*k+1]; e.vz = t[3*k+2];
      e.nx = nx; e.ny = ny; e.nz = nz;
      e.idx = next_vertex_index + k;
      e.last = (k == 2);
      e.degen = degen;
      expected_beats = {expected_beats, e};
    end
    next_vertex_index = next_vertex_index + 3;
  endfunction

  function automatic tri_t make_tri(logic [31:0] a, b, c, d, e, f, g, h, i);
    tri_t t;
    t[0] = a; t[1] = b; t[2] = c; t[3] = d; t[4] = e; t[5] = f;
    t[6] = g; t[7] = h; t[8] = i;
    return t;
  endfunction

  function automatic logic [31:0] small_coord();
    return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
  endfunction

  // driver: offer the next triangle, with random gaps except near the end
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      send_gap = 0;
    end else begin
      if (push && !full) begin
        predict_face({third_z, third_y, third_x, second_z, second_y, second_x,
                      first_z, first_y, first_x});
        faces_sent++;
      end
      if (!push || !full) begin
        if (send_gap > 0) begin
          send_gap--;
          push <= 1'b0;
        end else if (pending_faces.size() > 0) begin
          tri_t t;
          t = pending_faces.pop_front();
          {third_z, third_y, third_x, second_z, second_y, second_x,
           first_z, first_y, first_x} <= t;
          push <= 1'b1;
          if (pending_faces.size() > QUIET_TAIL && $urandom_range(0, 5) == 0)
            send_gap = $urandom_range(1, 13);
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, once, to back the block up to its input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && beats_seen >= HOLD_AT_BEAT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: take beats, check against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      recv_stall = 0;
    end else begin
      if (pop && !empty) begin
        beats_seen++;
        if (expected_beats.size() == 0) begin
          $error("unexpected beat: vertex_index=%0d", vertex_index);
          errors++;
        end else begin
          beat_t e;
          e = expected_beats.pop_front();
          if (vertex_x !== e.vx) begin
            $error("vertex_x exp %h got %h", e.vx, vertex_x); errors++;
          end
          if (vertex_y !== e.vy) begin
            $error("vertex_y exp %h got %h", e.vy, vertex_y); errors++;
          end
          if (vertex_z !== e.vz) begin
            $error("vertex_z exp %h got %h", e.vz, vertex_z); errors++;
          end
          if (normal_x !== e.nx) begin
            $error("normal_x exp %h got %h", e.nx, normal_x); errors++;
          end
          if (normal_y !== e.ny) begin
            $error("normal_y exp %h got %h", e.ny, normal_y); errors++;
          end
          if (normal_z !== e.nz) begin
            $error("normal_z exp %h got %h", e.nz, normal_z); errors++;
          end
          if (vertex_index !== e.idx) begin
            $error("vertex_index exp %0d got %0d", e.idx, vertex_index); errors++;
          end
          if (last_of_face !== e.last) begin
            $error("last_of_face exp %b got %b", e.last, last_of_face); errors++;
          end
          if (degenerate !== e.degen) begin
            $error("degenerate exp %b got %b", e.degen, degenerate); errors++;
          end
        end
      end
      if (hold_left > 0) begin
        pop <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if (faces_sent < total_faces - QUIET_TAIL && $urandom_range(0, 7) == 0)
          recv_stall = $urandom_range(1, 13);
      end
    end
  end

  // watchdog
  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // stimulus and end of run
  initial begin
    logic [31:0] mx, mn, one;
    logic [31:0] a, b, c, d, e, f;
    int kind;
    mx = 32'h7fff_ffff; mn = 32'h8000_0000; one = 32'h0001_0000;
    rst = 1'b1; push = 1'b0; pop = 1'b0;
    {first_x, first_y, first_z, second_x, second_y, second_z} = '0;
    {third_x, third_y, third_z} = '0;
    next_vertex_index = '0;
    errors = 0; faces_sent = 0; beats_seen = 0; degen_faces = 0;

    // directed: degenerate shapes, unit triangles, extremes of the range
    queue_face(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
    queue_face(make_tri(0, 0, 0, one, 0, 0, 0, one, 0));
    queue_face(make_tri(0, 0, 0, 0, one, 0, one, 0, 0));
    queue_face(make_tri(0, 0, 0, 0, 0, one, 0, one, 0));
    queue_face(make_tri(0, 0, 0, 1, 1, 1, 2, 2, 2));
    queue_face(make_tri(mx, mx, mx, mx, mx, mx, mx, mx, mx));
    queue_face(make_tri(mn, mn, mn, mx, mn, mn, mn, mx, mn));
    queue_face(make_tri(mx, mx, mx, mn, mx, mx, mx, mn, mx));
    queue_face(make_tri(mn, mn, mn, mx, mn, mx, mn, mx, mx));
    queue_face(make_tri(mn, mx, mn, mx, mn, mx, mn, mn, mx));
    queue_face(make_tri(1, 2, 3, 1, 2, 3, mx, mn, 0));
    queue_face(make_tri(5, 6, 7, mn, mx, 1, 5, 6, 7));
    queue_face(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
    queue_face(make_tri(-one, -one, -one, one, -one, 3*one, -one, one, one));
    queue_face(make_tri(32'hffff_ffff, 0, 1, 1, 32'hffff_ffff, 0,
                        0, 1, 32'hffff_ffff));

    // random: mostly full range, some small triangles, some degenerate ones
    for (int n = 0; n < RANDOM_FACES; n++) begin
      kind = $urandom_range(0, 19);
      if (kind < 13) begin
        queue_face(make_tri($urandom, $urandom, $urandom, $urandom,
          $urandom, $urandom, $urandom, $urandom, $urandom));
      end else if (kind < 17) begin
        queue_face(make_tri(small_coord(), small_coord(), small_coord(),
          small_coord(), small_coord(), small_coord(), small_coord(), small_coord(),
          small_coord()));
      end else begin
        // collinear: third = first + 2*(second - first)
        a = small_coord(); b = small_coord(); c = small_coord();
        d = small_coord(); e = small_coord(); f = small_coord();
        queue_face(make_tri(a, b, c, d, e, f,
          2*d - a, 2*e - b, 2*f - c));
      end
    end
    total_faces = pending_faces.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    wait (faces_sent == total_faces && expected_beats.size() == 0);
    repeat (400) @(posedge clk);
    $display("Covered %0d triangles (%0d degenerate), %0d vertex beats checked,",
             faces_sent, degen_faces, beats_seen);
    $display("with random idling on both sides and one long receiver hold-off.");
    if (errors == 0 && expected_beats.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ flat_shaded_triangle_emitter.f @@
rtl/fste_pkg.sv
rtl/fste_normal.sv
rtl/fste_fifo.sv
rtl/fste_emit.sv
rtl/flat_shaded_triangle_emitter.sv
tb/sv/tb_flat_shaded_triangle_emitter.sv
